>>> rtl/b64sc_pkg.sv
// Shared types, constants and character mapping functions for the Base64 stream codec.
// Depends on nothing; every other file of the codec refers to it by scoped names.
`default_nettype none

package b64sc_pkg;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic       MODE_ENCODE = 1'b0;
  localparam logic       MODE_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       out_error;
  } out_word_t;

  typedef struct packed {
    logic [RES_IDX_W-1:0]             last_idx;
    out_word_t [MAX_RESULTS-1:0]      res;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    begin
      w = {2'b00, v};
      if (v < 6'd26) return w + 8'h41;
      if (v < 6'd52) return w + 8'h47;
      if (v < 6'd62) return w - 8'd4;
      if (v == 6'd62) return 8'h2B;
      return 8'h2F;
    end
  endfunction

  // bit 6 set marks a character outside the alphabet
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
        d = c - 8'h41;
        return {1'b0, d[5:0]};
      end
      if (c >= 8'h61 && c <= 8'h7A) begin
        d = c - 8'h47;
        return {1'b0, d[5:0]};
      end
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c + 8'd4;
        return {1'b0, d[5:0]};
      end
      if (c == 8'h2B) return 7'd62;
      if (c == 8'h2F) return 7'd63;
      return 7'h40;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/b64sc_front.sv
// Front end: mode register, message state, and per-word result job building.
// Depends on b64sc_pkg; feeds b64sc_queue.
`default_nettype none

module b64sc_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data,
  input  wire logic                 src_valid,
  output logic                      src_stall,
  input  wire b64sc_pkg::in_word_t  src_data,
  input  wire b64sc_pkg::q_status_t q_stat,
  output b64sc_pkg::q_push_t        q_push
);

  logic       mode;
  logic [5:0] buffer;
  logic [2:0] count;
  logic [1:0] pad_seen;
  logic       failed;
  logic       any_output;

  logic [5:0] buffer_next;
  logic [2:0] count_next;
  logic [1:0] pad_seen_next;
  logic       failed_next;
  logic       any_output_next;

  logic       accept;
  logic [7:0] b;
  logic       last;
  logic [5:0] c0;
  logic [5:0] c1;
  logic [6:0] dv;
  logic       emit;
  logic [7:0] dbyte;
  logic [11:0] dw;
  b64sc_pkg::job_t job;
  logic        push;

  function automatic b64sc_pkg::out_word_t data_word(input logic [7:0] d, input logic l);
    b64sc_pkg::out_word_t w;
    begin
      w.out_byte  = d;
      w.out_valid = 1'b1;
      w.out_last  = l;
      w.out_error = 1'b0;
      return w;
    end
  endfunction

  function automatic b64sc_pkg::out_word_t marker_word(input logic e);
    b64sc_pkg::out_word_t w;
    begin
      w.out_byte  = 8'h00;
      w.out_valid = 1'b0;
      w.out_last  = 1'b1;
      w.out_error = e;
      return w;
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign src_stall = q_stat.full;
  assign accept    = src_valid && !q_stat.full;
  assign b         = src_data.in_byte;
  assign last      = src_data.in_last;
  assign dv        = b64sc_pkg::dec_value(b);
  assign dw        = {buffer, dv[5:0]};

  always_comb begin
    buffer_next     = buffer;
    count_next      = count;
    pad_seen_next   = pad_seen;
    failed_next     = failed;
    any_output_next = any_output;
    job             = '0;
    push            = 1'b0;
    c0              = 6'd0;
    c1              = 6'd0;
    emit            = 1'b0;
    dbyte           = 8'h00;
    if (mode == b64sc_pkg::MODE_ENCODE) begin
      push = 1'b1;
      unique case (count)
        3'd0: begin
          c0 = b[7:2];
          buffer_next = {4'b0000, b[1:0]};
          count_next = 3'd2;
          job.res[0] = data_word(b64sc_pkg::enc_char(c0), 1'b0);
          if (last) begin
            job.res[1] = data_word(b64sc_pkg::enc_char({b[1:0], 4'b0000}), 1'b0);
            job.res[2] = data_word(b64sc_pkg::PAD_CHAR, 1'b0);
            job.res[3] = data_word(b64sc_pkg::PAD_CHAR, 1'b1);
            job.last_idx = 2'd3;
          end
        end
        3'd2: begin
          c0 = {buffer[1:0], b[7:4]};
          buffer_next = {2'b00, b[3:0]};
          count_next = 3'd4;
          job.res[0] = data_word(b64sc_pkg::enc_char(c0), 1'b0);
          if (last) begin
            job.res[1] = data_word(b64sc_pkg::enc_char({b[3:0], 2'b00}), 1'b0);
            job.res[2] = data_word(b64sc_pkg::PAD_CHAR, 1'b1);
            job.last_idx = 2'd2;
          end
        end
        default: begin
          c0 = {buffer[3:0], b[7:6]};
          c1 = b[5:0];
          buffer_next = 6'd0;
          count_next = 3'd0;
          job.res[0] = data_word(b64sc_pkg::enc_char(c0), 1'b0);
          job.res[1] = data_word(b64sc_pkg::enc_char(c1), last);
          job.last_idx = 2'd1;
        end
      endcase
    end else begin
      if (!failed) begin
        if (b == b64sc_pkg::PAD_CHAR) begin
          if (pad_seen == 2'd2) failed_next = 1'b1;
          else pad_seen_next = pad_seen + 2'd1;
        end else if (dv[6] || pad_seen != 2'd0) begin
          failed_next = 1'b1;
        end else begin
          unique case (count)
            3'd0: begin
              buffer_next = dv[5:0];
              count_next = 3'd6;
            end
            3'd2: begin
              emit = 1'b1;
              dbyte = dw[7:0];
              count_next = 3'd0;
            end
            3'd4: begin
              emit = 1'b1;
              dbyte = dw[9:2];
              buffer_next = {4'b0000, dv[1:0]};
              count_next = 3'd2;
            end
            default: begin
              emit = 1'b1;
              dbyte = dw[11:4];
              buffer_next = {2'b00, dv[3:0]};
              count_next = 3'd4;
            end
          endcase
          if (emit) any_output_next = 1'b1;
        end
      end
      if (last) begin
        push = 1'b1;
        if (failed_next || !any_output_next) job.res[0] = marker_word(1'b1);
        else if (emit) job.res[0] = data_word(dbyte, 1'b1);
        else job.res[0] = marker_word(1'b0);
      end else begin
        push = emit;
        job.res[0] = data_word(dbyte, 1'b0);
      end
    end
  end

  assign q_push.push = accept && push;
  assign q_push.job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= b64sc_pkg::MODE_ENCODE;
      buffer     <= 6'd0;
      count      <= 3'd0;
      pad_seen   <= 2'd0;
      failed     <= 1'b0;
      any_output <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode       <= cfg_data;
      buffer     <= 6'd0;
      count      <= 3'd0;
      pad_seen   <= 2'd0;
      failed     <= 1'b0;
      any_output <= 1'b0;
    end else if (accept) begin
      if (last) begin
        buffer     <= 6'd0;
        count      <= 3'd0;
        pad_seen   <= 2'd0;
        failed     <= 1'b0;
        any_output <= 1'b0;
      end else begin
        buffer     <= buffer_next;
        count      <= count_next;
        pad_seen   <= pad_seen_next;
        failed     <= failed_next;
        any_output <= any_output_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/b64sc_queue.sv
// Short job queue between the front end and the output sequencer.
// Depends on b64sc_pkg.
`default_nettype none

module b64sc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire b64sc_pkg::q_push_t   q_push,
  input  wire logic                 pop,
  output b64sc_pkg::job_t           head,
  output b64sc_pkg::q_status_t      q_stat
);

  b64sc_pkg::job_t                    entries [b64sc_pkg::QUEUE_DEPTH];
  logic [b64sc_pkg::Q_PTR_W-1:0]      wr_ptr;
  logic [b64sc_pkg::Q_PTR_W-1:0]      rd_ptr;
  logic [b64sc_pkg::Q_CNT_W-1:0]      fill;
  logic                               do_pop;

  assign q_stat.empty = (fill == '0);
  assign q_stat.full  = (fill == b64sc_pkg::Q_CNT_W'(b64sc_pkg::QUEUE_DEPTH));
  assign head         = entries[rd_ptr];
  assign do_pop       = pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      entries[wr_ptr] <= q_push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (q_push.push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (q_push.push && !do_pop) fill <= fill + 1'b1;
      else if (!q_push.push && do_pop) fill <= fill - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/b64sc_back.sv
// Output sequencer: steps through each queued job and drives the output register.
// Depends on b64sc_pkg; takes jobs from b64sc_queue.
`default_nettype none

module b64sc_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire b64sc_pkg::job_t      head,
  input  wire b64sc_pkg::q_status_t q_stat,
  output logic                      pop,
  output logic                      dst_valid,
  input  wire logic                 dst_stall,
  output b64sc_pkg::out_word_t      dst_data
);

  logic [b64sc_pkg::RES_IDX_W-1:0] idx;
  logic                            load;

  assign load = !dst_valid || !dst_stall;
  assign pop  = load && !q_stat.empty && (idx == head.last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      if (!q_stat.empty) begin
        dst_valid <= 1'b1;
        if (idx == head.last_idx) idx <= '0;
        else idx <= idx + 1'b1;
      end else begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_stat.empty) begin
      dst_data <= head.res[idx];
    end
  end

endmodule

`default_nettype wire

>>> rtl/base64_stream_codec.sv
// Base64 stream codec top level: front end, job queue and output sequencer.
// An input word's results are registered in a queue entry, then in the output register.
// Throughput: one input word per cycle while the queue is not full and each yields at most
// one result word; one word out per cycle unless stalled; encode last word yields up to 4.
// Reset: synchronous rst clears mode to encode, message state, queue and output valid.
// Depends on b64sc_pkg, b64sc_front, b64sc_queue, b64sc_back.
`default_nettype none

module base64_stream_codec (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data,
  input  wire logic                 src_valid,
  output logic                      src_stall,
  input  wire b64sc_pkg::in_word_t  src_data,
  output logic                      dst_valid,
  input  wire logic                 dst_stall,
  output b64sc_pkg::out_word_t      dst_data
);

  b64sc_pkg::q_push_t   q_push;
  b64sc_pkg::q_status_t q_stat;
  b64sc_pkg::job_t      head;
  logic                 pop;

  b64sc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .q_stat    (q_stat),
    .q_push    (q_push)
  );

  b64sc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  b64sc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push.push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_error_marker: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_data.out_error) |-> (!dst_data.out_valid && dst_data.out_last))
    else $error("error word carries data or is not last");

  a_pop_sends: assert property (@(posedge clk) disable iff (rst)
    pop |=> dst_valid)
    else $error("job retired without output word");
`endif

endmodule

`default_nettype wire

>>> bench/tb_base64_stream_codec.sv
// Testbench for base64_stream_codec: directed table, then random encode/decode messages.
// Expected words come from a Base64 predictor or fixed rows; checked in arrival order.
// Depends on b64sc_pkg and base64_stream_codec.
`timescale 1ns / 100ps

module tb_base64_stream_codec;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 120;
  localparam int N_ROWS = 28;

  typedef enum logic {ROW_WORD, ROW_MODE} row_op_t;

  typedef struct packed {
    row_op_t   op;
    logic [7:0] val;
    logic      last;
    logic      fixed;
    b64sc_pkg::out_word_t res;
  } stim_row_t;

  localparam b64sc_pkg::out_word_t NO_RES   = '{8'h00, 1'b0, 1'b0, 1'b0};
  localparam b64sc_pkg::out_word_t MARK_END = '{8'h00, 1'b0, 1'b1, 1'b0};
  localparam b64sc_pkg::out_word_t MARK_ERR = '{8'h00, 1'b0, 1'b1, 1'b1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic src_valid = 1'b0;
  logic src_stall;
  b64sc_pkg::in_word_t src_data = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  b64sc_pkg::out_word_t dst_data;

  string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic sel_mode;
  logic [11:0] pend_bits;
  logic [3:0] pend_cnt;
  logic [1:0] pad_cnt;
  logic msg_bad;
  logic msg_has_byte;
  b64sc_pkg::out_word_t step_res [4];
  b64sc_pkg::out_word_t expected_words [$];

  bit src_calm = 1'b0;
  bit dst_calm = 1'b0;
  bit hold_req = 1'b0;
  int mismatches = 0;
  int unsigned cycle_cnt = 0;

  stim_row_t dir_rows [N_ROWS] = '{
    '{ROW_WORD, 8'h00, 1'b1, 1'b0, NO_RES},
    '{ROW_WORD, 8'hFF, 1'b0, 1'b1, '{8'h2F, 1'b1, 1'b0, 1'b0}},
    '{ROW_WORD, 8'hFF, 1'b1, 1'b0, NO_RES},
    '{ROW_WORD, 8'h4D, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, 8'h61, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, 8'h6E, 1'b1, 1'b0, NO_RES},
    '{ROW_MODE, {7'd0, b64sc_pkg::MODE_DECODE}, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, "Q", 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, "Q", 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, b64sc_pkg::PAD_CHAR, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, b64sc_pkg::PAD_CHAR, 1'b1, 1'b1, MARK_END},
    '{ROW_WORD, "T", 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, "W", 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, "E", 1'b1, 1'b0, NO_RES},
    '{ROW_WORD, "!", 1'b1, 1'b1, MARK_ERR},
    '{ROW_WORD, "Q", 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, "Q", 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, b64sc_pkg::PAD_CHAR, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, "Q", 1'b1, 1'b1, MARK_ERR},
    '{ROW_WORD, "Q", 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, "Q", 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, b64sc_pkg::PAD_CHAR, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, b64sc_pkg::PAD_CHAR, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, b64sc_pkg::PAD_CHAR, 1'b1, 1'b1, MARK_ERR},
    '{ROW_WORD, "Q", 1'b1, 1'b1, MARK_ERR},
    '{ROW_WORD, 8'hFF, 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, "Q", 1'b0, 1'b0, NO_RES},
    '{ROW_WORD, "Q", 1'b1, 1'b1, MARK_ERR}
  };

  base64_stream_codec i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_data(src_data),
    .dst_valid(dst_valid),
    .dst_stall(dst_stall),
    .dst_data(dst_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic b64sc_pkg::out_word_t mk_word(logic [7:0] ch, logic vld, logic lst,
                                                   logic err);
    return {ch, vld, lst, err};
  endfunction

  function automatic logic [6:0] sextet_of(logic [7:0] c);
    for (int i = 0; i < 64; i++)
      if (b64_alpha[i] == c) return 7'(i);
    return 7'h40;
  endfunction

  function automatic void clear_msg();
    pend_bits = '0;
    pend_cnt = '0;
    pad_cnt = '0;
    msg_bad = 1'b0;
    msg_has_byte = 1'b0;
  endfunction

  function automatic int codec_step(b64sc_pkg::in_word_t w);
    int n;
    int pads;
    logic [11:0] sh;
    logic [6:0] v;
    n = 0;
    pads = 0;
    if (sel_mode == b64sc_pkg::MODE_ENCODE) begin
      pend_bits = {pend_bits[3:0], w.in_byte};
      pend_cnt = pend_cnt + 4'd8;
      while (pend_cnt >= 4'd6) begin
        pend_cnt = pend_cnt - 4'd6;
        sh = pend_bits >> pend_cnt;
        step_res[n] = mk_word(b64_alpha[sh[5:0]], 1'b1, 1'b0, 1'b0);
        n++;
      end
      if (w.in_last) begin
        if (pend_cnt == 4'd2 || pend_cnt == 4'd4) begin
          pads = (pend_cnt == 4'd2) ? 2 : 1;
          sh = pend_bits << (4'd6 - pend_cnt);
          step_res[n] = mk_word(b64_alpha[sh[5:0]], 1'b1, 1'b0, 1'b0);
          n++;
        end
        for (int p = 0; p < pads; p++) begin
          step_res[n] = mk_word(b64sc_pkg::PAD_CHAR, 1'b1, 1'b0, 1'b0);
          n++;
        end
        step_res[n-1].out_last = 1'b1;
        clear_msg();
      end else begin
        pend_bits = pend_bits & ((12'd1 << pend_cnt) - 12'd1);
      end
    end else begin
      if (!msg_bad) begin
        if (w.in_byte == b64sc_pkg::PAD_CHAR) begin
          if (pad_cnt >= 2'd2) msg_bad = 1'b1;
          else pad_cnt = pad_cnt + 2'd1;
        end else begin
          v = sextet_of(w.in_byte);
          if (v[6] || pad_cnt != 2'd0) begin
            msg_bad = 1'b1;
          end else begin
            pend_bits = (pend_bits << 6) | {6'd0, v[5:0]};
            pend_cnt = pend_cnt + 4'd6;
            if (pend_cnt >= 4'd8) begin
              pend_cnt = pend_cnt - 4'd8;
              sh = pend_bits >> pend_cnt;
              step_res[n] = mk_word(sh[7:0], 1'b1, 1'b0, 1'b0);
              n++;
              msg_has_byte = 1'b1;
            end
            pend_bits = pend_bits & ((12'd1 << pend_cnt) - 12'd1);
          end
        end
      end
      if (w.in_last) begin
        if (msg_bad || !msg_has_byte) begin
          step_res[0] = MARK_ERR;
          n = 1;
        end else if (n > 0) begin
          step_res[n-1].out_last = 1'b1;
        end else begin
          step_res[0] = MARK_END;
          n = 1;
        end
        clear_msg();
      end
    end
    return n;
  endfunction

  task automatic send_word(input b64sc_pkg::in_word_t w, input logic fixed,
                           input b64sc_pkg::out_word_t fixed_res);
    int gap;
    int n;
    gap = src_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data <= w;
    do @(posedge clk); while (src_stall !== 1'b0);
    n = codec_step(w);
    if (fixed) expected_words.push_back(fixed_res);
    else for (int k = 0; k < n; k++) expected_words.push_back(step_res[k]);
  endtask

  task automatic settle();
    src_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sel_mode = m;
    clear_msg();
  endtask

  task automatic send_message(input int len, input bit closed);
    int npad;
    logic [7:0] b;
    npad = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
    if (npad > len - 1) npad = len - 1;
    for (int i = 0; i < len; i++) begin
      if (sel_mode == b64sc_pkg::MODE_ENCODE) b = 8'($urandom_range(0, 255));
      else if (i < len - npad) b = b64_alpha[$urandom_range(0, 63)];
      else b = b64sc_pkg::PAD_CHAR;
      if (sel_mode == b64sc_pkg::MODE_DECODE && $urandom_range(0, 15) == 0)
        b = $urandom_range(0, 1) ? b64sc_pkg::PAD_CHAR : 8'($urandom_range(0, 255));
      send_word({b, closed && i == len - 1}, 1'b0, NO_RES);
    end
  endtask

  initial begin : stimulus
    int sent;
    int len;
    logic m;
    sel_mode = b64sc_pkg::MODE_ENCODE;
    clear_msg();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int r = 0; r < N_ROWS; r++) begin
      if (dir_rows[r].op == ROW_MODE) set_mode(dir_rows[r].val[0]);
      else send_word({dir_rows[r].val, dir_rows[r].last}, dir_rows[r].fixed, dir_rows[r].res);
    end
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0) m = b64sc_pkg::MODE_ENCODE;
      else if (ph == 1) m = b64sc_pkg::MODE_DECODE;
      else m = 1'($urandom_range(0, 1));
      set_mode(m);
      src_calm = (ph % 3 == 2);
      dst_calm = (ph % 3 == 2);
      if (ph == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < 15) begin
        len = (sel_mode == b64sc_pkg::MODE_ENCODE) ? $urandom_range(1, 6) : $urandom_range(2, 9);
        send_message(len, 1'b1);
        sent += len;
      end
      if ($urandom_range(0, 1)) send_message($urandom_range(1, 3), 1'b0);
    end
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin : sink
    int wait_n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        dst_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        wait_n = dst_calm ? 0 : $urandom_range(0, 3);
        if (wait_n > 0) begin
          dst_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
      end
      dst_stall <= 1'b0;
      do @(posedge clk); while (dst_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : result_check
    b64sc_pkg::out_word_t want;
    if (!rst && dst_valid === 1'b1 && dst_stall === 1'b0) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: %h", dst_data);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (dst_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, dst_data.out_byte);
          mismatches++;
        end
        if (dst_data.out_valid !== want.out_valid) begin
          $error("out_valid: expected %b, got %b", want.out_valid, dst_data.out_valid);
          mismatches++;
        end
        if (dst_data.out_last !== want.out_last) begin
          $error("out_last: expected %b, got %b", want.out_last, dst_data.out_last);
          mismatches++;
        end
        if (dst_data.out_error !== want.out_error) begin
          $error("out_error: expected %b, got %b", want.out_error, dst_data.out_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
